### sv/dhoat_pkg.sv
// ----------------------------------------------------------------------------
// dhoat_pkg: shared types and constants of the double hash table
// Hash constants, slot marks, status codes and the front-to-back job type.
// ----------------------------------------------------------------------------
`default_nettype none
package dhoat_pkg;
  localparam int TableDepthDef = 1024;
  localparam int KeyBytesDef   = 8;
  localparam int ValueBitsDef  = 32;

  localparam logic [31:0] HashSeed = 32'h0012_3456;
  localparam logic [31:0] HashMult = 32'h5bd1_e995;
  localparam int          HashShr  = 15;
  localparam int          K33Shl   = 5;

  localparam logic [10:0] SizeReset = 11'd1024;

  localparam logic [1:0] ModeInsert  = 2'd0;
  localparam logic [1:0] ModeRemove  = 2'd1;
  localparam logic [1:0] ModeLookup  = 2'd2;
  localparam logic [1:0] ModeInvalid = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StMissing = 2'd2;

  localparam logic [1:0] MarkEmpty   = 2'd0;
  localparam logic [1:0] MarkUsed    = 2'd1;
  localparam logic [1:0] MarkDeleted = 2'd2;

  // job from hashing front to probing back
  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] value;
    logic [31:0] n_hash;
    logic [31:0] k_hash;
  } job_t;
endpackage
`default_nettype wire

### sv/dhoat_front.sv
// ----------------------------------------------------------------------------
// dhoat_front: key normalisation and hashing
// Takes one beat, clears bytes past the terminator, hashes a byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module dhoat_front #(
  parameter int KEY_BYTES  = dhoat_pkg::KeyBytesDef,
  parameter int VALUE_BITS = dhoat_pkg::ValueBitsDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_mode,
  input  wire logic [63:0]           in_key_bytes,
  input  wire logic [31:0]           in_item_value,
  output logic                       job_valid,
  input  wire logic                  job_ready,
  output dhoat_pkg::job_t            job
);
  localparam int LenW = $clog2(KEY_BYTES + 1);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_MIX, S_OUT} state_t;

  state_t          state_r;
  logic [1:0]      mode_r;
  logic [63:0]     key_r;
  logic [63:0]     val_r;
  logic [LenW-1:0] len_r, idx_r;
  logic [31:0]     n_r, k_r;

  logic [63:0]     norm;
  logic [LenW-1:0] len;
  logic            stop;
  logic [7:0]      byte_c;
  logic [31:0]     sb;
  logic [31:0]     nx;
  logic [63:0]     vmask;

  always_comb begin
    norm = '0;
    len  = '0;
    stop = 1'b0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (!stop && in_key_bytes[8*i +: 8] != 8'd0) begin
        norm[8*i +: 8] = in_key_bytes[8*i +: 8];
        len = LenW'(i + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  always_comb begin
    vmask = '0;
    vmask[VALUE_BITS-1:0] = '1;
  end

  assign byte_c = key_r[8*idx_r +: 8];
  assign sb     = {{24{byte_c[7]}}, byte_c};
  assign nx     = n_r ^ sb;

  assign in_ready  = (state_r == S_IDLE);
  assign job_valid = (state_r == S_OUT);
  assign job = '{mode: mode_r, key: key_r, value: val_r, n_hash: n_r, k_hash: k_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          mode_r  <= in_mode;
          key_r   <= norm;
          val_r   <= {32'd0, in_item_value} & vmask;
          len_r   <= len;
          idx_r   <= '0;
          n_r     <= dhoat_pkg::HashSeed;
          k_r     <= dhoat_pkg::HashSeed;
          state_r <= (len == '0) ? S_OUT : S_HASH;
        end
        S_HASH: begin
          // multiply in this cycle, xor-shift in the next
          n_r     <= nx * dhoat_pkg::HashMult;
          k_r     <= (k_r << dhoat_pkg::K33Shl) + k_r + sb;
          idx_r   <= idx_r + 1'b1;
          state_r <= S_MIX;
        end
        S_MIX: begin
          n_r     <= n_r ^ (n_r >> dhoat_pkg::HashShr);
          state_r <= (idx_r == len_r) ? S_OUT : S_HASH;
        end
        S_OUT: if (job_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/dhoat_fifo.sv
// ----------------------------------------------------------------------------
// dhoat_fifo: two-entry job queue
// Decouples hashing from probing.
// ----------------------------------------------------------------------------
`default_nettype none
module dhoat_fifo (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_valid,
  output logic            wr_ready,
  input  dhoat_pkg::job_t wr_data,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output dhoat_pkg::job_t rd_data
);
  dhoat_pkg::job_t mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

### sv/dhoat_back.sv
// ----------------------------------------------------------------------------
// dhoat_back: probe sequencer and slot stores
// Reduces both hashes and the 32-bit wrap term modulo m by restoring
// division, then walks the probe path one slot at a time (read, wait, eval, step).
// ----------------------------------------------------------------------------
`default_nettype none
module dhoat_back #(
  parameter int TABLE_DEPTH = dhoat_pkg::TableDepthDef,
  parameter int VALUE_BITS  = dhoat_pkg::ValueBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_table_size,
  input  wire logic        job_valid,
  output logic             job_ready,
  input  dhoat_pkg::job_t  job,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value,
  output logic [9:0]       out_slot_index,
  output logic             clearing
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int MW = AW + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_READ, S_WAIT, S_EVAL, S_STEP, S_DONE
  } state_t;

  logic [1:0]         mark_mem [TABLE_DEPTH];
  logic [63:0]        key_mem  [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];

  state_t        state_r;
  logic [10:0]   size_r;
  logic [MW-1:0] count_r;
  dhoat_pkg::job_t job_r;
  logic [MW-1:0] m_r;
  logic [AW-1:0] clr_r;
  logic [5:0]    bit_r;
  logic [1:0]    which_r;
  logic [MW-1:0] rem_r;
  logic [AW-1:0] pos_r, kstep_r, wrap_r;
  logic [31:0]   acc_r;
  logic [MW-1:0] t_r;
  logic [1:0]    mark_q;
  logic [63:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [1:0]    st_r;
  logic [31:0]   fv_r;
  logic [AW-1:0] idx_r;

  logic [MW-1:0] m_eff;
  logic [31:0]   dividend;
  logic [MW:0]   trial;
  logic [MW-1:0] rem_nx;
  logic [MW:0]   psum;
  logic [AW-1:0] pos_nx;
  logic [32:0]   acc_sum;
  logic [AW-1:0] pos_fix;
  logic [63:0]   fv_wide;

  always_comb begin
    if (size_r < 11'd2)                          m_eff = MW'(2);
    else if ({21'd0, size_r} > 32'(TABLE_DEPTH)) m_eff = MW'(TABLE_DEPTH);
    else                                         m_eff = MW'(size_r);
  end

  // one restoring-division step on n, k, or 2^32 - m (which gives 2^32 mod m)
  always_comb begin
    if (which_r == 2'd0)      dividend = job_r.n_hash;
    else if (which_r == 2'd1) dividend = job_r.k_hash;
    else                      dividend = 32'd0 - 32'(m_r);
  end
  assign trial    = {rem_r, dividend[bit_r[4:0]]};
  assign rem_nx   = (trial >= {1'b0, m_r}) ? MW'(trial - {1'b0, m_r}) : trial[MW-1:0];

  // (n + t*k) mod m, stepped: add k mod m, then subtract m if the sum reaches m
  assign psum   = {2'b00, pos_r} + {2'b00, kstep_r};
  assign pos_nx = (psum >= {1'b0, m_r}) ? AW'(psum - {1'b0, m_r}) : AW'(psum);

  // n + t*k wraps at 32 bits: on a carry take 2^32 mod m off again
  assign acc_sum = {1'b0, acc_r} + {1'b0, job_r.k_hash};
  assign pos_fix = !acc_sum[32]       ? pos_nx :
                   (pos_nx >= wrap_r) ? pos_nx - wrap_r :
                   AW'({1'b0, pos_nx} + m_r - {1'b0, wrap_r});

  assign cfg_ready = 1'b1;
  assign clearing  = (state_r == S_CLEAR);
  assign job_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_status      = st_r;
  assign out_found_value = fv_r;
  assign out_slot_index  = 10'(idx_r);
  assign fv_wide = 64'(val_q);

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      mark_q <= mark_mem[pos_r];
      key_q  <= key_mem[pos_r];
      val_q  <= val_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      mark_mem[clr_r] <= dhoat_pkg::MarkEmpty;
    end else if (state_r == S_EVAL) begin
      if (job_r.mode == dhoat_pkg::ModeInsert && mark_q != dhoat_pkg::MarkUsed) begin
        mark_mem[pos_r] <= dhoat_pkg::MarkUsed;
      end else if (job_r.mode == dhoat_pkg::ModeRemove && mark_q == dhoat_pkg::MarkUsed
                   && key_q == job_r.key) begin
        mark_mem[pos_r] <= dhoat_pkg::MarkDeleted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EVAL && job_r.mode == dhoat_pkg::ModeInsert
        && mark_q != dhoat_pkg::MarkUsed) begin
      key_mem[pos_r] <= job_r.key;
      val_mem[pos_r] <= job_r.value[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      size_r  <= dhoat_pkg::SizeReset;
      count_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cfg_valid) size_r <= cfg_table_size;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(TABLE_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (job_valid) begin
          job_r   <= job;
          m_r     <= m_eff;
          rem_r   <= '0;
          bit_r   <= 6'd31;
          which_r <= 2'd0;
          t_r     <= '0;
          st_r    <= dhoat_pkg::StMissing;
          fv_r    <= '0;
          idx_r   <= '0;
          if (job.mode == dhoat_pkg::ModeInsert && ({1'b0, count_r} + 1'b1) >= {1'b0, m_eff}) begin
            st_r    <= dhoat_pkg::StFull;
            state_r <= S_DONE;
          end else if (job.mode != dhoat_pkg::ModeInsert && job.mode != dhoat_pkg::ModeRemove
                       && job.mode != dhoat_pkg::ModeLookup) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (bit_r == 6'd0) begin
            rem_r <= '0;
            bit_r <= 6'd31;
            if (which_r == 2'd0) begin
              pos_r   <= AW'(rem_nx);
              which_r <= 2'd1;
            end else if (which_r == 2'd1) begin
              kstep_r <= AW'(rem_nx);
              which_r <= 2'd2;
            end else begin
              wrap_r  <= AW'(rem_nx);
              acc_r   <= job_r.n_hash;
              state_r <= S_READ;
            end
          end else begin
            rem_r <= rem_nx;
            bit_r <= bit_r - 1'b1;
          end
        end
        S_READ: state_r <= S_WAIT;
        S_WAIT: state_r <= S_EVAL;
        S_EVAL: begin
          if (job_r.mode == dhoat_pkg::ModeInsert) begin
            if (mark_q != dhoat_pkg::MarkUsed) begin
              st_r    <= dhoat_pkg::StOk;
              idx_r   <= pos_r;
              count_r <= count_r + 1'b1;
              state_r <= S_DONE;
            end else begin
              st_r    <= dhoat_pkg::StFull;
              state_r <= S_STEP;
            end
          end else if (mark_q == dhoat_pkg::MarkEmpty) begin
            state_r <= S_DONE;
          end else if (mark_q == dhoat_pkg::MarkUsed && key_q == job_r.key) begin
            st_r    <= dhoat_pkg::StOk;
            idx_r   <= pos_r;
            if (job_r.mode == dhoat_pkg::ModeLookup) fv_r <= fv_wide[31:0];
            state_r <= S_DONE;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_STEP: begin
          t_r   <= t_r + 1'b1;
          pos_r <= pos_fix;
          acc_r <= acc_sum[31:0];
          state_r <= (t_r + 1'b1 == m_r) ? S_DONE : S_READ;
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/double_hash_open_address_table_top.sv
// ----------------------------------------------------------------------------
// double_hash_open_address_table_top: open-addressing hash table
// Insert, remove and lookup of byte-string keys with double hashing.
// ----------------------------------------------------------------------------
// Each input beat is one operation (mode 0 insert, 1 remove, 2 lookup) and
// gives exactly one result beat. The front hashes the key one byte at a
// time (multiply, then xor-shift); a two-entry queue lets it hash the next
// key while the back still probes. The back first reduces both hashes and
// the 32-bit wrap term 2^32 mod m modulo the table size with a bit-serial
// divider, then visits one slot at a time (read, registered data, compare,
// step); the number of probes is bounded by the table size. After reset
// the back clears the slot marks before it takes the first operation;
// configuration writes are taken at any time. table_size is clamped to
// 2..TABLE_DEPTH.
`default_nettype none
module double_hash_open_address_table_top #(
  parameter int TABLE_DEPTH = dhoat_pkg::TableDepthDef,
  parameter int KEY_BYTES   = dhoat_pkg::KeyBytesDef,
  parameter int VALUE_BITS  = dhoat_pkg::ValueBitsDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_table_size,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [63:0] in_key_bytes,
  input  wire logic [31:0] in_item_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [31:0]      out_found_value,
  output logic [9:0]       out_slot_index
);
  dhoat_pkg::job_t f_job, b_job;
  logic f_valid, f_ready, b_valid, b_ready;
  logic clearing;
  logic fe_in_valid, fe_in_ready;

  // hold off input beats during the post-reset clear of the marks
  assign fe_in_valid = in_valid && !clearing;
  assign in_ready    = fe_in_ready && !clearing;

  dhoat_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk, .rst_n,
    .in_valid(fe_in_valid), .in_ready(fe_in_ready),
    .in_mode, .in_key_bytes, .in_item_value,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  dhoat_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  dhoat_back #(.TABLE_DEPTH(TABLE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_table_size,
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_valid, .out_ready, .out_status, .out_found_value, .out_slot_index,
    .clearing
  );
endmodule
`default_nettype wire
